>>> rtl/adc_measurement_scaler_ntc_unit_defines.svh
// ----------------------------------------------------------------------------
// ADC measurement scaler assertion macros
// Concurrent checks clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ADC_MEASUREMENT_SCALER_NTC_UNIT_DEFINES_SVH
`define ADC_MEASUREMENT_SCALER_NTC_UNIT_DEFINES_SVH

// same-cycle implication
`define AMSN_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("amsn check failed");

// next-cycle implication
`define AMSN_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("amsn check failed");

`endif

>>> rtl/amsn_pkg.sv
// ----------------------------------------------------------------------------
// ADC measurement scaler package
// Shared constants, register codes and the elaboration-time NTC table
// generator.
// ----------------------------------------------------------------------------
package amsn_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int PIPE_DEPTH      = 4;
    localparam int CFG_DATA_BITS   = 28;
    localparam int CFG_IDX_BITS    = 3;
    localparam int TEMP_BITS       = 14;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_VOLT_GAIN = 3'd0,
        CFG_VOLT_OFF  = 3'd1,
        CFG_PGA_GAIN  = 3'd2,
        CFG_PGA_OFF   = 3'd3,
        CFG_DIR_GAIN  = 3'd4,
        CFG_DIR_OFF   = 3'd5
    } t_cfg_idx;

    localparam logic [15:0] PGA_HIGH_LIMIT   = 16'd4000;
    localparam logic [15:0] THERM_LOW_LIMIT  = 16'd10;
    localparam logic [15:0] THERM_HIGH_LIMIT = 16'd4085;

    // unsigned divide by 100: (a * DIV100_MUL) >> DIV100_SHIFT, exact below 2^32
    localparam int          DIV100_MUL_BITS = 31;
    localparam logic [30:0] DIV100_MUL      = 31'd1374389535;
    localparam int          DIV100_SHIFT    = 37;

    localparam logic signed [TEMP_BITS-1:0] TEMP_AT_ZERO  = -14'sd500;
    localparam logic signed [TEMP_BITS-1:0] TEMP_AT_FULL  = 14'sd2000;
    localparam logic signed [TEMP_BITS-1:0] TEMP_SAT_HIGH = 14'sd8191;

    localparam logic [63:0]        LN2_Q30        = 64'd744261118;
    localparam logic signed [63:0] DEN_BASE_Q20   = 64'sd398800 <<< 20;
    localparam logic signed [63:0] T25_X100       = 64'sd29815;
    localparam logic [63:0]        NUM_Q32        = 64'd1189022200 << 32;
    localparam logic signed [63:0] KELVIN_OFF_Q12 = 64'sd11188224;

    function automatic logic [63:0] log2_q28(input logic [63:0] n);
        logic [63:0] m;
        logic [63:0] frac;
        int          msb;
        msb = 0;
        for (int i = 1; i < 63; i++) begin
            if ((n >> i) != 64'd0) begin
                msb = i;
            end
        end
        m    = n << (30 - msb);
        frac = 64'd0;
        for (int k = 0; k < 28; k++) begin
            m    = (m * m) >> 30;
            frac = {frac[62:0], 1'b0};
            if (m >= 64'h8000_0000) begin
                m       = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return (64'(msb) << 28) | frac;
    endfunction

    // restoring long division
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = 64'd0;
        quo = 64'd0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic signed [TEMP_BITS-1:0] ntc_entry(input int sb, input int x);
        logic [63:0]        full;
        logic [63:0]        xv;
        logic [63:0]        prod;
        logic [63:0]        lnmag;
        logic [63:0]        tq;
        logic signed [63:0] d;
        logic signed [63:0] ln20;
        logic signed [63:0] den;
        logic signed [63:0] v;
        logic signed [63:0] r;
        logic               neg;
        full = 64'd1 << sb;
        xv   = 64'(x);
        if (xv == 64'd0) begin
            return TEMP_AT_ZERO;
        end
        if (xv >= full - 64'd1) begin
            return TEMP_AT_FULL;
        end
        d     = $signed(log2_q28(xv)) - $signed(log2_q28(full - xv));
        neg   = d[63];
        prod  = (neg ? $unsigned(-d) : $unsigned(d)) * LN2_Q30;
        lnmag = prod >> 38;
        ln20  = neg ? -$signed(lnmag) : $signed(lnmag);
        den   = DEN_BASE_Q20 + T25_X100 * ln20;
        if (den <= 64'sd0) begin
            return TEMP_SAT_HIGH;
        end
        tq = udiv64(NUM_Q32, $unsigned(den));
        v  = $signed(tq) - KELVIN_OFF_Q12;
        if (v >= 64'sd0) begin
            r = (v + 64'sd2048) >>> 12;
        end else begin
            r = -((-v + 64'sd2048) >>> 12);
        end
        if (r > 64'sd8191) begin
            r = 64'sd8191;
        end
        if (r < -64'sd8192) begin
            r = -64'sd8192;
        end
        return r[TEMP_BITS-1:0];
    endfunction

endpackage

>>> rtl/amsn_rom.sv
// ----------------------------------------------------------------------------
// NTC temperature ROM
// One entry per thermistor code, built at elaboration, registered read.
// ----------------------------------------------------------------------------
module amsn_rom #(
    parameter int SAMPLE_BITS = amsn_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic [SAMPLE_BITS-1:0]                 i_addr,
    output logic signed [amsn_pkg::TEMP_BITS-1:0]  o_data
);

    localparam int DEPTH = 1 << SAMPLE_BITS;

    logic signed [amsn_pkg::TEMP_BITS-1:0] w_rom [DEPTH];
    logic signed [amsn_pkg::TEMP_BITS-1:0] r_data;

    for (genvar a = 0; a < DEPTH; a++) begin : g_rom
        localparam logic signed [amsn_pkg::TEMP_BITS-1:0] ENTRY =
            amsn_pkg::ntc_entry(SAMPLE_BITS, a);
        assign w_rom[a] = ENTRY;
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_rom[i_addr];
    end

    assign o_data = r_data;

endmodule

>>> rtl/amsn_volt.sv
// ----------------------------------------------------------------------------
// Voltage scaling lane
// Sample times gain, divided by 100, plus the offset when it is not negative.
// ----------------------------------------------------------------------------
module amsn_volt #(
    parameter int SAMPLE_BITS = amsn_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [15:0]            i_gain,
    input  logic [15:0]            i_offset,
    output logic [15:0]            o_value
);

    localparam int PW = SAMPLE_BITS + 16;
    localparam int QW = PW + amsn_pkg::DIV100_MUL_BITS;
    localparam int QS = amsn_pkg::DIV100_SHIFT;

    logic [PW-1:0] r_prod;
    logic [PW-1:0] r_prod_d;
    logic [QW-1:0] r_qprod;
    logic [15:0]   r_value;
    logic [15:0]   n_value;

    always_comb begin
        n_value = r_qprod[QS+15:QS] + (i_offset[15] ? 16'd0 : i_offset);
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= PW'(i_sample) * PW'(i_gain);
        r_prod_d <= r_prod;
        r_qprod  <= QW'(r_prod_d) * QW'(amsn_pkg::DIV100_MUL);
        r_value  <= n_value;
    end

    assign o_value = r_value;

endmodule

>>> rtl/amsn_curr.sv
// ----------------------------------------------------------------------------
// Current scaling lane
// Sample times signed gain plus signed offset, divided by 100 toward zero.
// ----------------------------------------------------------------------------
module amsn_curr #(
    parameter int SAMPLE_BITS = amsn_pkg::SAMPLE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic [SAMPLE_BITS-1:0]   i_sample,
    input  logic signed [15:0]       i_gain,
    input  logic signed [27:0]       i_offset,
    output logic signed [15:0]       o_value
);

    localparam int PW = SAMPLE_BITS + 17;
    localparam int MW = (SAMPLE_BITS + 15 > 27) ? SAMPLE_BITS + 16 : 28;
    localparam int SW = MW + 1;
    localparam int QW = MW + amsn_pkg::DIV100_MUL_BITS;
    localparam int QS = amsn_pkg::DIV100_SHIFT;

    logic signed [PW-1:0] w_samp_x;
    logic signed [PW-1:0] w_gain_x;
    logic signed [SW-1:0] w_sum;
    logic [15:0]          w_quot;
    logic signed [PW-1:0] r_prod;
    logic [MW-1:0]        r_mag;
    logic                 r_neg;
    logic                 r_neg_d;
    logic [QW-1:0]        r_qprod;
    logic signed [15:0]   r_value;
    logic signed [15:0]   n_value;

    assign w_samp_x = PW'($signed({1'b0, i_sample}));
    assign w_gain_x = PW'(i_gain);
    assign w_sum    = SW'(r_prod) + SW'(i_offset);
    assign w_quot   = r_qprod[QS+15:QS];

    always_comb begin
        n_value = r_neg_d ? $signed(-w_quot) : $signed(w_quot);
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= w_samp_x * w_gain_x;
        r_neg   <= w_sum[SW-1];
        r_mag   <= w_sum[SW-1] ? MW'(-w_sum) : MW'(w_sum);
        r_neg_d <= r_neg;
        r_qprod <= QW'(r_mag) * QW'(amsn_pkg::DIV100_MUL);
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

>>> rtl/adc_measurement_scaler_ntc_unit.sv
// ----------------------------------------------------------------------------
// ADC measurement scaler with NTC thermistor
// Raise start with four samples while busy is low; the word is taken at that
// edge. After the output stage o_done pulses for one cycle with the
// voltage, both currents, the temperature and the status flags. A new word
// is taken every cycle while busy is low, so one result leaves per cycle;
// the receiver cannot stall and must capture each result in its o_done cycle.
// Stages: multiply, offset add (voltage: delay), divide-by-100 multiply, output.
// Temperature comes from a ROM of 2^SAMPLE_BITS entries read at accept.
// Configuration: write i_cfg_data to register i_cfg_idx with i_cfg_we high,
// only while no word is in flight; indices past the list are dropped.
// Reset (synchronous, i_rst_n low) zeroes the configuration registers and valid
// bits, drops words in flight and keeps busy high to the first edge with i_rst_n high.
// ----------------------------------------------------------------------------
module adc_measurement_scaler_ntc_unit #(
    parameter int SAMPLE_BITS = amsn_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [SAMPLE_BITS-1:0]                 i_voltage_sample,
    input  logic [SAMPLE_BITS-1:0]                 i_pga_current_sample,
    input  logic [SAMPLE_BITS-1:0]                 i_direct_current_sample,
    input  logic [SAMPLE_BITS-1:0]                 i_thermistor_sample,
    input  logic                                   i_cfg_we,
    input  logic [amsn_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [amsn_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    output logic                                   o_done,
    output logic [15:0]                            o_voltage_decivolts,
    output logic signed [15:0]                     o_pga_current_deciamps,
    output logic signed [15:0]                     o_direct_current_deciamps,
    output logic signed [amsn_pkg::TEMP_BITS-1:0]  o_temperature_decidegrees,
    output logic [2:0]                             o_sample_flags
);

    localparam int DEPTH = amsn_pkg::PIPE_DEPTH;

    logic [15:0]        r_volt_gain;
    logic [15:0]        r_volt_off;
    logic signed [15:0] r_pga_gain;
    logic signed [27:0] r_pga_off;
    logic signed [15:0] r_dir_gain;
    logic signed [27:0] r_dir_off;
    logic               r_busy;
    logic [DEPTH-1:0]   r_valid;
    logic [DEPTH-1:0]   n_valid;
    logic [2:0]         r_flags [DEPTH];
    logic [2:0]         n_flags;
    logic signed [amsn_pkg::TEMP_BITS-1:0] r_temp [DEPTH-1];
    logic signed [amsn_pkg::TEMP_BITS-1:0] w_rom_data;
    logic               w_accept;

    assign w_accept = start & ~r_busy;

    always_comb begin
        n_valid    = {r_valid[DEPTH-2:0], w_accept};
        n_flags[0] = 16'(i_pga_current_sample) > amsn_pkg::PGA_HIGH_LIMIT;
        n_flags[1] = i_direct_current_sample != '0;
        n_flags[2] = (16'(i_thermistor_sample) < amsn_pkg::THERM_LOW_LIMIT) ||
                     (16'(i_thermistor_sample) > amsn_pkg::THERM_HIGH_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_valid <= '0;
        end else begin
            r_busy  <= 1'b0;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volt_gain <= '0;
            r_volt_off  <= '0;
            r_pga_gain  <= '0;
            r_pga_off   <= '0;
            r_dir_gain  <= '0;
            r_dir_off   <= '0;
        end else if (i_cfg_we) begin
            case (amsn_pkg::t_cfg_idx'(i_cfg_idx))
                amsn_pkg::CFG_VOLT_GAIN: r_volt_gain <= i_cfg_data[15:0];
                amsn_pkg::CFG_VOLT_OFF:  r_volt_off  <= i_cfg_data[15:0];
                amsn_pkg::CFG_PGA_GAIN:  r_pga_gain  <= $signed(i_cfg_data[15:0]);
                amsn_pkg::CFG_PGA_OFF:   r_pga_off   <= $signed(i_cfg_data[27:0]);
                amsn_pkg::CFG_DIR_GAIN:  r_dir_gain  <= $signed(i_cfg_data[15:0]);
                amsn_pkg::CFG_DIR_OFF:   r_dir_off   <= $signed(i_cfg_data[27:0]);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_flags[0] <= n_flags;
        for (int i = 1; i < DEPTH; i++) begin
            r_flags[i] <= r_flags[i-1];
        end
        r_temp[0] <= w_rom_data;
        for (int i = 1; i < DEPTH - 1; i++) begin
            r_temp[i] <= r_temp[i-1];
        end
    end

    amsn_rom #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (i_thermistor_sample),
        .o_data (w_rom_data)
    );

    amsn_volt #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_volt (
        .i_clk    (i_clk),
        .i_sample (i_voltage_sample),
        .i_gain   (r_volt_gain),
        .i_offset (r_volt_off),
        .o_value  (o_voltage_decivolts)
    );

    amsn_curr #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_pga (
        .i_clk    (i_clk),
        .i_sample (i_pga_current_sample),
        .i_gain   (r_pga_gain),
        .i_offset (r_pga_off),
        .o_value  (o_pga_current_deciamps)
    );

    amsn_curr #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_dir (
        .i_clk    (i_clk),
        .i_sample (i_direct_current_sample),
        .i_gain   (r_dir_gain),
        .i_offset (r_dir_off),
        .o_value  (o_direct_current_deciamps)
    );

    assign busy                      = r_busy;
    assign o_done                    = r_valid[DEPTH-1];
    assign o_sample_flags            = r_flags[DEPTH-1];
    assign o_temperature_decidegrees = r_temp[DEPTH-2];

endmodule

>>> rtl/amsn_chk.sv
// ----------------------------------------------------------------------------
// ADC measurement scaler port checker
// Timing and special-value checks on the top-level ports, bound to the top.
// ----------------------------------------------------------------------------
`include "adc_measurement_scaler_ntc_unit_defines.svh"

module amsn_chk #(
    parameter int SAMPLE_BITS = amsn_pkg::SAMPLE_BITS_DEF
) (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   start,
    input logic                                   busy,
    input logic [SAMPLE_BITS-1:0]                 i_pga_current_sample,
    input logic [SAMPLE_BITS-1:0]                 i_thermistor_sample,
    input logic                                   o_done,
    input logic signed [amsn_pkg::TEMP_BITS-1:0]  o_temperature_decidegrees,
    input logic [2:0]                             o_sample_flags
);

    localparam int DEPTH = amsn_pkg::PIPE_DEPTH;

    logic w_pga_high;
    logic w_therm_zero;
    logic w_temp_zero;

    assign w_pga_high   = 16'(i_pga_current_sample) > amsn_pkg::PGA_HIGH_LIMIT;
    assign w_therm_zero = i_thermistor_sample == '0;
    assign w_temp_zero  = o_temperature_decidegrees == amsn_pkg::TEMP_AT_ZERO;

    `AMSN_ASSERT_IMP(a_done_after_start, o_done, $past(start && !busy, DEPTH))
    `AMSN_ASSERT_IMP(a_start_gives_done, start && !busy, ##DEPTH o_done)
    `AMSN_ASSERT_IMP(a_pga_flag, o_done, o_sample_flags[0] == $past(w_pga_high, DEPTH))
    `AMSN_ASSERT_IMP(a_temp_at_zero, o_done && $past(w_therm_zero, DEPTH), w_temp_zero)
    `AMSN_ASSERT_NXT(a_busy_stays_low, !busy, !busy)

endmodule

bind adc_measurement_scaler_ntc_unit amsn_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_amsn_chk (.*);

>>> test/adc_measurement_scaler_ntc_unit_tb.sv
// ----------------------------------------------------------------------------
// ADC measurement scaler testbench
// Drives sample words through the start/busy handshake under random gaps,
// predicts voltage, both currents, the NTC temperature and the status flags
// from a local copy of the registers, and checks every o_done word in order.
// Registers are reprogrammed between phases once the pipeline has drained.
// ----------------------------------------------------------------------------
module adc_measurement_scaler_ntc_unit_tb;
    import amsn_pkg::*;

    localparam int SB          = SAMPLE_BITS_DEF;
    localparam int SAMPLE_MAX  = (1 << SB) - 1;
    localparam int FULL_COUNT  = 1 << SB;
    localparam int DRAIN_LIMIT = 200;
    localparam int MAX_SHOWN   = 10;
    localparam int PHASES      = 7;
    localparam int PHASE_WORDS = 250;

    localparam int PGA_SAT_CODE     = 4000;
    localparam int THERM_SHORT_CODE = 10;
    localparam int THERM_OPEN_CODE  = 4085;
    localparam int FLAG_PGA_HIGH    = 0;
    localparam int FLAG_DIR_LIVE    = 1;
    localparam int FLAG_THERM_BAD   = 2;

    localparam logic [CFG_IDX_BITS-1:0] SPARE_IDX_A = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] SPARE_IDX_B = 3'd7;

    localparam logic signed [15:0] S16_MIN = 16'sh8000;
    localparam logic signed [15:0] S16_MAX = 16'sh7FFF;
    localparam logic signed [27:0] OFF_MIN = -28'sd100000000;
    localparam logic signed [27:0] OFF_MAX = 28'sd100000000;

    localparam longint LN2_FRAC    = 64'sd744261118;
    localparam longint LN_DIVISOR  = 64'sd1 <<< 38;
    localparam longint DENOM_BASE  = 64'sd398800 <<< 20;
    localparam longint BETA_SCALE  = 64'sd29815;
    localparam longint KELVIN_NUM  = 64'sd1189022200 <<< 32;
    localparam longint ZERO_C_Q12  = 64'sd11188224;
    localparam longint TEMP_BOTTOM = -500;
    localparam longint TEMP_TOP    = 2000;
    localparam longint TEMP_CLAMP_HI = 8191;
    localparam longint TEMP_CLAMP_LO = -8192;

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic [SB-1:0] volt;
        logic [SB-1:0] pga;
        logic [SB-1:0] dir;
        logic [SB-1:0] therm;
    } sample_set_t;

    typedef struct packed {
        logic [15:0]                  volts;
        logic signed [15:0]           pga_amps;
        logic signed [15:0]           dir_amps;
        logic signed [TEMP_BITS-1:0]  temp;
        logic [2:0]                   flags;
    } meas_t;

    typedef struct packed {
        logic [15:0]        volt_gain;
        logic signed [15:0] volt_off;
        logic signed [15:0] pga_gain;
        logic signed [27:0] pga_off;
        logic signed [15:0] dir_gain;
        logic signed [27:0] dir_off;
    } cfg_t;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              start;
    logic                              busy;
    logic [SB-1:0]                     i_voltage_sample;
    logic [SB-1:0]                     i_pga_current_sample;
    logic [SB-1:0]                     i_direct_current_sample;
    logic [SB-1:0]                     i_thermistor_sample;
    logic                              i_cfg_we;
    logic [CFG_IDX_BITS-1:0]           i_cfg_idx;
    logic [CFG_DATA_BITS-1:0]          i_cfg_data;
    logic                              o_done;
    logic [15:0]                       o_voltage_decivolts;
    logic signed [15:0]                o_pga_current_deciamps;
    logic signed [15:0]                o_direct_current_deciamps;
    logic signed [TEMP_BITS-1:0]       o_temperature_decidegrees;
    logic [2:0]                        o_sample_flags;

    cfg_t        active_cfg;
    meas_t       pending_meas[$];
    int unsigned err_count = 0;
    int unsigned burst_left = 0;

    adc_measurement_scaler_ntc_unit i_dut (
        .i_clk                     (i_clk),
        .i_rst_n                   (i_rst_n),
        .start                     (start),
        .busy                      (busy),
        .i_voltage_sample          (i_voltage_sample),
        .i_pga_current_sample      (i_pga_current_sample),
        .i_direct_current_sample   (i_direct_current_sample),
        .i_thermistor_sample       (i_thermistor_sample),
        .i_cfg_we                  (i_cfg_we),
        .i_cfg_idx                 (i_cfg_idx),
        .i_cfg_data                (i_cfg_data),
        .o_done                    (o_done),
        .o_voltage_decivolts       (o_voltage_decivolts),
        .o_pga_current_deciamps    (o_pga_current_deciamps),
        .o_direct_current_deciamps (o_direct_current_deciamps),
        .o_temperature_decidegrees (o_temperature_decidegrees),
        .o_sample_flags            (o_sample_flags)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic u64_t fixed_log2(u64_t n);
        u64_t        mant;
        u64_t        frac;
        int unsigned lead;
        lead = 0;
        while (lead < 62 && (n >> (lead + 1)) != 0) begin
            lead++;
        end
        mant = n << (30 - lead);
        frac = 0;
        repeat (28) begin
            mant = (mant * mant) >> 30;
            frac = frac << 1;
            if (mant >= 64'h8000_0000) begin
                mant = mant >> 1;
                frac = frac | 64'd1;
            end
        end
        return (u64_t'(lead) << 28) | frac;
    endfunction

    function automatic logic signed [TEMP_BITS-1:0] ntc_decidegrees(logic [SB-1:0] code);
        longint ratio_log;
        longint ln_q20;
        longint denom;
        longint excess;
        longint rounded;
        if (code == 0) begin
            return TEMP_BITS'(TEMP_BOTTOM);
        end
        if (code >= FULL_COUNT - 1) begin
            return TEMP_BITS'(TEMP_TOP);
        end
        ratio_log = longint'(fixed_log2(u64_t'(code)))
                  - longint'(fixed_log2(u64_t'(FULL_COUNT - code)));
        ln_q20 = (ratio_log * LN2_FRAC) / LN_DIVISOR;
        denom  = DENOM_BASE + BETA_SCALE * ln_q20;
        if (denom <= 0) begin
            return TEMP_BITS'(TEMP_CLAMP_HI);
        end
        excess = KELVIN_NUM / denom - ZERO_C_Q12;
        if (excess >= 0) begin
            rounded = (excess + 2048) / 4096;
        end else begin
            rounded = -((-excess + 2048) / 4096);
        end
        if (rounded > TEMP_CLAMP_HI) begin
            rounded = TEMP_CLAMP_HI;
        end
        if (rounded < TEMP_CLAMP_LO) begin
            rounded = TEMP_CLAMP_LO;
        end
        return TEMP_BITS'(rounded);
    endfunction

    function automatic logic signed [15:0] scale_current(logic [SB-1:0] sample,
                                                         logic signed [15:0] gain,
                                                         logic signed [27:0] offset);
        longint milliamps;
        milliamps = longint'(sample) * longint'(gain) + longint'(offset);
        return 16'(milliamps / 100);
    endfunction

    function automatic meas_t predict_meas(sample_set_t s);
        meas_t m;
        u64_t  volts;
        volts = (u64_t'(s.volt) * u64_t'(active_cfg.volt_gain)) / 100;
        if (!active_cfg.volt_off[15]) begin
            volts = volts + u64_t'(active_cfg.volt_off);
        end
        m.volts    = volts[15:0];
        m.pga_amps = scale_current(s.pga, active_cfg.pga_gain, active_cfg.pga_off);
        m.dir_amps = scale_current(s.dir, active_cfg.dir_gain, active_cfg.dir_off);
        m.temp     = ntc_decidegrees(s.therm);
        m.flags    = '0;
        m.flags[FLAG_PGA_HIGH]  = s.pga > PGA_SAT_CODE;
        m.flags[FLAG_DIR_LIVE]  = s.dir != 0;
        m.flags[FLAG_THERM_BAD] = s.therm < THERM_SHORT_CODE || s.therm > THERM_OPEN_CODE;
        return m;
    endfunction

    function automatic int unsigned next_gap();
        if (burst_left != 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic logic [SB-1:0] draw_sample();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return SB'(SAMPLE_MAX);
            2: return SB'($urandom_range(0, 15));
            3: return SB'($urandom_range(SAMPLE_MAX - 110, SAMPLE_MAX));
            default: return SB'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] draw_s16();
        case ($urandom_range(0, 7))
            0: return S16_MIN;
            1: return S16_MAX;
            2: return 16'sd0;
            3: return -16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [27:0] draw_offset();
        case ($urandom_range(0, 7))
            0: return OFF_MIN;
            1: return OFF_MAX;
            2: return 28'sd0;
            3: return 28'(int'($urandom_range(0, 2000)) - 1000);
            default: return 28'(int'($urandom_range(0, 200000000)) - 100000000);
        endcase
    endfunction

    function automatic cfg_t random_cfg();
        cfg_t c;
        case ($urandom_range(0, 5))
            0: c.volt_gain = 16'hFFFF;
            1: c.volt_gain = 16'($urandom_range(0, 255));
            default: c.volt_gain = 16'($urandom);
        endcase
        c.volt_off = draw_s16();
        c.pga_gain = draw_s16();
        c.pga_off  = draw_offset();
        c.dir_gain = draw_s16();
        c.dir_off  = draw_offset();
        return c;
    endfunction

    // leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_VOLT_GAIN: active_cfg.volt_gain = data[15:0];
            CFG_VOLT_OFF:  active_cfg.volt_off  = data[15:0];
            CFG_PGA_GAIN:  active_cfg.pga_gain  = data[15:0];
            CFG_PGA_OFF:   active_cfg.pga_off   = data[27:0];
            CFG_DIR_GAIN:  active_cfg.dir_gain  = data[15:0];
            CFG_DIR_OFF:   active_cfg.dir_off   = data[27:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input cfg_t c);
        write_reg(CFG_VOLT_GAIN, {12'($urandom), c.volt_gain});
        write_reg(CFG_VOLT_OFF, {12'($urandom), c.volt_off});
        write_reg(CFG_PGA_GAIN, {12'($urandom), c.pga_gain});
        write_reg(CFG_PGA_OFF, c.pga_off);
        write_reg(CFG_DIR_GAIN, {12'($urandom), c.dir_gain});
        write_reg(CFG_DIR_OFF, c.dir_off);
        i_cfg_we <= 1'b0;
    endtask

    // leaves start high so back-to-back words need no extra edge
    task automatic send_samples(input sample_set_t s);
        int unsigned gap;
        gap = next_gap();
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start                   <= 1'b1;
        i_voltage_sample        <= s.volt;
        i_pga_current_sample    <= s.pga;
        i_direct_current_sample <= s.dir;
        i_thermistor_sample     <= s.therm;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_meas.push_back(predict_meas(s));
    endtask

    task automatic drain_results();
        int unsigned waited;
        waited = 0;
        start <= 1'b0;
        while (pending_meas.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_meas.size() != 0) begin
            err_count += pending_meas.size();
            $display("%0d words never came out", pending_meas.size());
            pending_meas.delete();
        end
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : check_results
        meas_t got;
        meas_t want;
        if (o_done === 1'b1) begin
            got.volts    = o_voltage_decivolts;
            got.pga_amps = o_pga_current_deciamps;
            got.dir_amps = o_direct_current_deciamps;
            got.temp     = o_temperature_decidegrees;
            got.flags    = o_sample_flags;
            if (pending_meas.size() == 0) begin
                err_count++;
                if (err_count <= MAX_SHOWN) begin
                    $display("unexpected word: volts=%0d pga=%0d dir=%0d temp=%0d flags=%b",
                             got.volts, got.pga_amps, got.dir_amps, got.temp, got.flags);
                end
            end else begin
                want = pending_meas.pop_front();
                if (got !== want) begin
                    err_count++;
                    if (err_count <= MAX_SHOWN) begin
                        $display("mismatch at %0t", $realtime);
                        $display("  exp volts=%0d pga=%0d dir=%0d temp=%0d flags=%b",
                                 want.volts, want.pga_amps, want.dir_amps, want.temp,
                                 want.flags);
                        $display("  got volts=%0d pga=%0d dir=%0d temp=%0d flags=%b",
                                 got.volts, got.pga_amps, got.dir_amps, got.temp,
                                 got.flags);
                    end
                end
            end
        end
    end

    task automatic test_reset_state();
        send_samples('{SB'(0), SB'(0), SB'(0), SB'(0)});
        send_samples('{SB'(SAMPLE_MAX), SB'(SAMPLE_MAX), SB'(SAMPLE_MAX), SB'(SAMPLE_MAX)});
        drain_results();
    endtask

    task automatic test_thermistor_curve();
        int          therm_codes [11] = '{0, 1, 9, 10, 11, 2048, 4084, 4085, 4086, 4094, 4095};
        int          pga_edges [4]    = '{4000, 4001, 4095, 0};
        sample_set_t s;
        apply_config('{16'd1000, 16'sd5, 16'sd100, 28'sd0, -16'sd100, 28'sd50});
        for (int i = 0; i < 11; i++) begin
            s.volt  = SB'(i * 372);
            s.pga   = SB'(pga_edges[i % 4]);
            s.dir   = SB'(i % 2);
            s.therm = SB'(therm_codes[i]);
            send_samples(s);
        end
        drain_results();
    endtask

    task automatic test_scaling_extremes();
        apply_config('{16'hFFFF, S16_MAX, S16_MIN, OFF_MIN, S16_MAX, OFF_MAX});
        send_samples('{SB'(SAMPLE_MAX), SB'(SAMPLE_MAX), SB'(SAMPLE_MAX), SB'(SAMPLE_MAX)});
        send_samples('{SB'(0), SB'(0), SB'(0), SB'(2000)});
        drain_results();
        // negative voltage offset must be dropped
        apply_config('{16'hFFFF, -16'sd1, S16_MAX, OFF_MAX, S16_MIN, OFF_MIN});
        send_samples('{SB'(SAMPLE_MAX), SB'(SAMPLE_MAX), SB'(SAMPLE_MAX), SB'(1000)});
        send_samples('{SB'(1), SB'(1), SB'(1), SB'(3000)});
        drain_results();
        // truncation toward zero on small currents
        apply_config('{16'd1, S16_MIN, -16'sd1, -28'sd99, 16'sd1, 28'sd199});
        send_samples('{SB'(99), SB'(1), SB'(0), SB'(500)});
        send_samples('{SB'(SAMPLE_MAX), SB'(SAMPLE_MAX), SB'(1), SB'(3500)});
        drain_results();
    endtask

    task automatic test_spare_index();
        write_reg(SPARE_IDX_A, 28'hFFF_FFFF);
        write_reg(SPARE_IDX_B, 28'h555_5555);
        i_cfg_we <= 1'b0;
        send_samples('{SB'(1234), SB'(4001), SB'(77), SB'(9)});
        send_samples('{SB'(SAMPLE_MAX), SB'(0), SB'(SAMPLE_MAX), SB'(4086)});
        drain_results();
    endtask

    task automatic test_random_phases();
        sample_set_t s;
        for (int p = 0; p < PHASES; p++) begin
            apply_config(random_cfg());
            repeat (PHASE_WORDS) begin
                s.volt  = draw_sample();
                s.pga   = draw_sample();
                s.dir   = draw_sample();
                s.therm = draw_sample();
                send_samples(s);
            end
            drain_results();
        end
    endtask

    initial begin
        start                   <= 1'b0;
        i_voltage_sample        <= '0;
        i_pga_current_sample    <= '0;
        i_direct_current_sample <= '0;
        i_thermistor_sample     <= '0;
        i_cfg_we                <= 1'b0;
        i_cfg_idx               <= '0;
        i_cfg_data              <= '0;
        i_rst_n                 <= 1'b0;
        active_cfg = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);

        test_reset_state();
        test_thermistor_curve();
        test_scaling_extremes();
        test_spare_index();
        test_random_phases();

        drain_results();
        if (err_count == 0) begin
            $display("[adc_measurement_scaler_ntc_unit] OK");
        end else begin
            $display("[adc_measurement_scaler_ntc_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[adc_measurement_scaler_ntc_unit] ERROR");
        $finish;
    end

endmodule

>>> adc_measurement_scaler_ntc_unit.f
+incdir+rtl
rtl/amsn_pkg.sv
rtl/amsn_rom.sv
rtl/amsn_volt.sv
rtl/amsn_curr.sv
rtl/adc_measurement_scaler_ntc_unit.sv
rtl/amsn_chk.sv
test/adc_measurement_scaler_ntc_unit_tb.sv
